@@ rtl/core/sgpd_pkg.sv @@
// Shared types, constants and the 3x3 neighborhood classifier for the gap point detector.
package sgpd_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int MAX_HEIGHT    = 4096;

    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int COLOR_W      = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int ROW_W        = 13;
    localparam int POINT_X_W    = 11;
    localparam int POINT_Y_W    = 12;
    localparam int KIND_W       = 2;
    localparam int WIN_W        = 18;
    localparam int LB_ENTRY_W   = 4;   // {two rows up, one row up}, 2 bits each

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_COLOR = 2'd2;

    localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH  = 12'd2048;
    localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT = 13'd4096;
    localparam logic [COLOR_W-1:0]      RST_TARGET_COLOR = 32'd0;

    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENDPOINT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CORNER   = 2'd2;

    // neighbor offsets in raster order, center skipped
    localparam logic signed [1:0] NB_DX [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                                 2'sd1, -2'sd1, 2'sd0, 2'sd1};
    localparam logic signed [1:0] NB_DY [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                                 2'sd0, 2'sd1, 2'sd1, 2'sd1};
    localparam logic [3:0] NB_POS [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8};

    typedef struct packed {
        logic                 live;       // column and row inside the image
        logic [1:0]           cur;        // {in_selection, differs}
        logic                 has_a1;
        logic                 has_a2;
        logic                 col_start;
        logic                 judge;      // window center lies inside the image
        logic                 done;
        logic [POINT_X_W-1:0] px;
        logic [POINT_Y_W-1:0] py;
    } pos_info_t;

    function automatic logic [KIND_W-1:0] classify(input logic [WIN_W-1:0] win);
        logic [7:0]        ink;
        logic [3:0]        n;
        logic              neg_pair;
        logic              all_pos;
        logic signed [3:0] sx;
        logic signed [3:0] sy;
        logic signed [5:0] dot;
        logic [1:0]        b;
        logic [KIND_W-1:0] k;
        k        = KIND_NONE;
        neg_pair = 1'b0;
        all_pos  = 1'b1;
        sx       = '0;
        sy       = '0;
        for (int i = 0; i < 8; i++)
        begin
            b      = win[2*NB_POS[i] +: 2];
            ink[i] = !b[1] || b[0];
        end
        n = 4'($countones(ink));
        for (int i = 0; i < 8; i++)
        begin
            if (ink[i])
            begin
                sx = sx + 4'(NB_DX[i]);
                sy = sy + 4'(NB_DY[i]);
            end
            for (int j = i + 1; j < 8; j++)
            begin
                dot = 6'(NB_DX[i]) * 6'(NB_DX[j]) + 6'(NB_DY[i]) * 6'(NB_DY[j]);
                if (ink[i] && ink[j] && dot < 0)
                    neg_pair = 1'b1;
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            dot = 6'(sx) * 6'(NB_DX[i]) + 6'(sy) * 6'(NB_DY[i]);
            if (ink[i] && dot <= 0)
                all_pos = 1'b0;
        end
        if (win[9:8] == 2'b11)
        begin
            if (n == 4'd1)
                k = KIND_ENDPOINT;
            else if (n == 4'd2 && !neg_pair)
                k = KIND_CORNER;
            else if (n == 4'd3 && !neg_pair)
                k = KIND_ENDPOINT;
            else if (n == 4'd4 && all_pos)
                k = KIND_ENDPOINT;
        end
        return k;
    endfunction

endpackage

@@ rtl/core/sgpd_linebuf.sv @@
// Line buffer memory: two rows of pixel bit pairs per column, registered read.
module sgpd_linebuf #(
    parameter int MAX_WIDTH = sgpd_pkg::DEF_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
    output logic [sgpd_pkg::LB_ENTRY_W-1:0]   rd_data,
    input  logic                              wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]      wr_addr,
    input  logic [sgpd_pkg::LB_ENTRY_W-1:0]   wr_data
);
    import sgpd_pkg::*;

    logic [LB_ENTRY_W-1:0] mem [MAX_WIDTH];
    logic [LB_ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/sgpd_scan.sv @@
// Raster position counters and per-item position decode against the clamped frame size.
module sgpd_scan #(
    parameter int MAX_WIDTH = sgpd_pkg::DEF_MAX_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [sgpd_pkg::WIDTH_REG_W-1:0]    image_width,
    input  logic [sgpd_pkg::HEIGHT_REG_W-1:0]   image_height,
    input  logic [sgpd_pkg::COLOR_W-1:0]        target_color,
    input  logic [sgpd_pkg::COLOR_W-1:0]        pixel_value,
    input  logic                                in_selection,
    output sgpd_pkg::pos_info_t                 info,
    output logic [$clog2(MAX_WIDTH)-1:0]        addr
);
    import sgpd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    eff_w;
    logic [ROW_W-1:0] eff_h;
    logic [31:0]      w32;
    logic [31:0]      h32;
    logic [CW-1:0]    col_m1;
    logic [ROW_W-1:0] row_m1;
    logic             col_in;
    logic             row_in;

    always_comb
    begin
        w32 = 32'(image_width);
        h32 = 32'(image_height);
        if (w32 == 32'd0)
            eff_w = CW'(1);
        else if (w32 > 32'(MAX_WIDTH))
            eff_w = CW'(MAX_WIDTH);
        else
            eff_w = CW'(w32);
        if (h32 == 32'd0)
            eff_h = ROW_W'(1);
        else if (h32 > 32'(MAX_HEIGHT))
            eff_h = ROW_W'(MAX_HEIGHT);
        else
            eff_h = ROW_W'(h32);
    end

    assign col_m1 = col_reg - CW'(1);
    assign row_m1 = row_reg - ROW_W'(1);
    assign col_in = col_reg < eff_w;
    assign row_in = row_reg < eff_h;

    always_comb
    begin
        info.live      = col_in && row_in;
        info.cur       = (col_in && row_in) ?
                         {in_selection, pixel_value != target_color} : 2'b00;
        info.has_a1    = col_in && (row_reg >= ROW_W'(1));
        info.has_a2    = col_in && (row_reg >= ROW_W'(2));
        info.col_start = col_reg == '0;
        info.judge     = (col_reg != '0) && (row_reg != '0) &&
                         (col_m1 < eff_w) && (row_m1 < eff_h);
        info.done      = !col_in && !row_in;
        info.px        = POINT_X_W'(col_m1);
        info.py        = POINT_Y_W'(row_m1);
    end

    assign addr = AW'(col_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (!col_in)
            begin
                col_next = '0;
                row_next = row_in ? row_reg + ROW_W'(1) : '0;
            end
            else
                col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ rtl/core/sgpd_classify.sv @@
// Read-data stage: window shift, line buffer write-back, classification and output register.
module sgpd_classify #(
    parameter int MAX_WIDTH = sgpd_pkg::DEF_MAX_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    output logic                                in_ready,
    input  sgpd_pkg::pos_info_t                 info,
    input  logic [$clog2(MAX_WIDTH)-1:0]        addr,
    input  logic [sgpd_pkg::LB_ENTRY_W-1:0]     rd_data,
    output logic                                wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]        wr_addr,
    output logic [sgpd_pkg::LB_ENTRY_W-1:0]     wr_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sgpd_pkg::KIND_W-1:0]         out_kind,
    output logic [sgpd_pkg::POINT_X_W-1:0]      out_x,
    output logic [sgpd_pkg::POINT_Y_W-1:0]      out_y,
    output logic                                out_last
);
    import sgpd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic                  s1_valid_reg, s1_valid_next;
    pos_info_t             s1_info_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic [WIN_W-1:0]      win_reg, win_next;
    logic                  out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]     out_kind_reg, out_kind_next;
    logic [POINT_X_W-1:0]  out_x_reg;
    logic [POINT_Y_W-1:0]  out_y_reg;
    logic                  out_last_reg;
    logic                  advance;
    logic [1:0]            a1;
    logic [1:0]            a2;
    logic [1:0]            newest;
    logic [WIN_W-1:0]      base;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    assign a1 = s1_info_reg.has_a1 ? rd_data[1:0] : 2'b00;
    assign a2 = s1_info_reg.has_a2 ? rd_data[3:2] : 2'b00;

    // each row slides one column left, the newest bit pair enters on the right
    always_comb
    begin
        base = s1_info_reg.col_start ? '0 : win_reg;
        for (int i = 0; i < 3; i++)
        begin
            newest = (i == 0) ? a2 : ((i == 1) ? a1 : s1_info_reg.cur);
            win_next[6*i +: 2]     = base[6*i + 2 +: 2];
            win_next[6*i + 2 +: 2] = base[6*i + 4 +: 2];
            win_next[6*i + 4 +: 2] = newest;
        end
        out_kind_next = s1_info_reg.judge ? classify(win_next) : KIND_NONE;
    end

    // consecutive in-image items never share a column, so no read/write overlap
    assign wr_en   = advance && s1_info_reg.live;
    assign wr_addr = s1_addr_reg;
    assign wr_data = {rd_data[1:0], s1_info_reg.cur};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
            s1_addr_reg <= addr;
        end
        if (advance)
        begin
            out_kind_reg <= out_kind_next;
            out_x_reg    <= (out_kind_next != KIND_NONE) ? s1_info_reg.px : '0;
            out_y_reg    <= (out_kind_next != KIND_NONE) ? s1_info_reg.py : '0;
            out_last_reg <= s1_info_reg.done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;

endmodule

@@ rtl/core/stroke_gap_point_detector.sv @@
// Top level of the stroke gap point detector: config registers and stage wiring.
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+---------------------------------
//  cfg       | in  | cfg_wr_en                     | cfg_wr_index, cfg_wr_data
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata pixel_value, tuser in_selection
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata point_x/point_y, tuser kind,
//            |     |                               | tlast frame_done
//
// One request per clock sustained while m_axis_tready is high; each request passes the line
// buffer read, then the window update and output register, before its result appears.
// The line buffer RAM port reads on accept and writes back when the request advances to output.
// Reset clears counters, window and valids; line buffer contents start undefined.
// A stalled output holds one result and one request in flight, then drops s_axis_tready.
module stroke_gap_point_detector #(
    parameter int MAX_WIDTH = sgpd_pkg::DEF_MAX_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [sgpd_pkg::CFG_INDEX_W-1:0]       cfg_wr_index,
    input  logic [sgpd_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [31:0]                            s_axis_tdata,  // [31:0] pixel_value
    input  logic [0:0]                             s_axis_tuser,  // [0] in_selection
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [23:0]                            m_axis_tdata,  // [10:0] point_x,
                                                                  // [22:11] point_y, [23] 0
    output logic [1:0]                             m_axis_tuser,  // [1:0] kind
    output logic                                   m_axis_tlast   // frame_done
);
    import sgpd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [WIDTH_REG_W-1:0]  image_width_reg;
    logic [HEIGHT_REG_W-1:0] image_height_reg;
    logic [COLOR_W-1:0]      target_color_reg;

    logic                  accept;
    pos_info_t             info;
    logic [AW-1:0]         addr;
    logic [LB_ENTRY_W-1:0] rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [LB_ENTRY_W-1:0] wr_data;
    logic [POINT_X_W-1:0]  out_x;
    logic [POINT_Y_W-1:0]  out_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            target_color_reg <= RST_TARGET_COLOR;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wr_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wr_data[HEIGHT_REG_W-1:0];
                REG_TARGET_COLOR: target_color_reg <= cfg_wr_data[COLOR_W-1:0];
                default:          ;
            endcase
        end
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    sgpd_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .target_color (target_color_reg),
        .pixel_value  (s_axis_tdata),
        .in_selection (s_axis_tuser[0]),
        .info         (info),
        .addr         (addr)
    );

    // pad rows still need the rows above, so every request reads
    sgpd_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    sgpd_classify #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_ready  (s_axis_tready),
        .info      (info),
        .addr      (addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_y, out_x};

endmodule

@@ rtl/core/sgpd_checker.sv @@
// Port-level checker for the stroke gap point detector, bound to the top level.
module sgpd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import sgpd_pkg::*;

    // held result must not change under backpressure
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // empty output register means the pipeline can always take a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_NONE || m_axis_tuser == KIND_ENDPOINT
                           || m_axis_tuser == KIND_CORNER))
        else $error("illegal kind code");

    a_none_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_NONE |-> m_axis_tdata == '0)
        else $error("position reported without a point");

    // a result only appears after a request was taken
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid
            || $past(s_axis_tvalid && s_axis_tready, 2) || $past(m_axis_tvalid))
        else $error("result without request");

endmodule

bind stroke_gap_point_detector sgpd_checker u_sgpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
